// ===== hw/rtl/mhpq_pkg.sv =====
// shared types and constants of the max-heap priority queue
package mhpq_pkg;

	localparam int VALUE_W     = 32;
	localparam int TOTAL_W     = 8;
	localparam int STATUS_W    = 2;
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [VALUE_W-1:0] value_t;

	// request kinds as they arrive on req_type
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// status codes of a result
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_REJECT_FULL,
		OP_REJECT_EMPTY
	} op_t;

	typedef struct packed {
		op_t    op;
		value_t value;
	} request_t;

endpackage

// ===== hw/rtl/mhpq_front.sv =====
// request intake: accepts requests and classifies them against a running count
module mhpq_front #(
	parameter int CAPACITY = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   req_type,
	input  mhpq_pkg::value_t       push_value,
	input  logic                   q_full,
	output logic                   busy,
	output logic                   q_push,
	output mhpq_pkg::request_t     q_req
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] shadow_count_q;
	logic             accept;

	assign busy   = q_full;
	assign accept = start && !q_full;
	assign q_push = accept;

	// classify against the count the heap will hold once earlier requests finish
	always_comb begin
		q_req.value = push_value;
		unique case (req_type)
			mhpq_pkg::REQ_PUSH: begin
				if (shadow_count_q >= CNT_W'(CAPACITY)) begin
					q_req.op = mhpq_pkg::OP_REJECT_FULL;
				end else begin
					q_req.op = mhpq_pkg::OP_PUSH;
				end
			end
			default: begin
				if (shadow_count_q == '0) begin
					q_req.op = mhpq_pkg::OP_REJECT_EMPTY;
				end else begin
					q_req.op = mhpq_pkg::OP_POP;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count_q <= '0;
		end else if (accept) begin
			if (q_req.op == mhpq_pkg::OP_PUSH) begin
				shadow_count_q <= shadow_count_q + CNT_W'(1);
			end else if (q_req.op == mhpq_pkg::OP_POP) begin
				shadow_count_q <= shadow_count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/mhpq_queue.sv =====
// short request queue between intake and heap engine
module mhpq_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mhpq_pkg::request_t push_req,
	input  logic               pop,
	output mhpq_pkg::request_t head,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = $clog2(mhpq_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mhpq_pkg::QUEUE_DEPTH + 1);

	mhpq_pkg::request_t slot_q [mhpq_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (fill_q == CNT_W'(mhpq_pkg::QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == PTR_W'(mhpq_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PTR_W'(1);
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_W'(mhpq_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PTR_W'(1);
				end
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/mhpq_back.sv =====
// heap engine: heap memory, sift-up and sift-down sequencer, result register
module mhpq_back #(
	parameter int CAPACITY = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mhpq_pkg::request_t              q_head,
	input  logic                            q_empty,
	output logic                            q_pop,
	output logic                            done,
	output mhpq_pkg::value_t                removed_value,
	output mhpq_pkg::value_t                top_value,
	output logic [mhpq_pkg::TOTAL_W-1:0]    entry_total,
	output logic [mhpq_pkg::STATUS_W-1:0]   status
);

	localparam int POS_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int LW     = POS_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_LAST,
		S_DOWN,
		S_DOWN_CMP,
		S_REPORT
	} state_t;

	state_t                        state_q;
	state_t                        state_d;
	logic [POS_W-1:0]              count_q;
	logic [POS_W-1:0]              pos_q;
	logic [POS_W-1:0]              pos_d;
	mhpq_pkg::value_t              value_q;
	mhpq_pkg::value_t              removed_q;
	logic [mhpq_pkg::STATUS_W-1:0] status_q;
	logic                          done_q;
	mhpq_pkg::value_t              top_out_q;
	logic [mhpq_pkg::TOTAL_W-1:0]  total_q;

	logic [31:0]                   heap_mem [CAPACITY];
	mhpq_pkg::value_t              rd_a_q;
	mhpq_pkg::value_t              rd_b_q;
	mhpq_pkg::value_t              top_q;

	logic [ADDR_W-1:0]             rd_addr_a;
	logic [ADDR_W-1:0]             rd_addr_b;
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	mhpq_pkg::value_t              wr_data;

	logic [LW-1:0]                 left_pos;
	logic [LW-1:0]                 right_pos;
	logic [LW-1:0]                 count_ext;
	logic                          has_left;
	logic                          take_right;
	mhpq_pkg::value_t              child_val;
	logic [POS_W-1:0]              child_pos;
	logic [POS_W-1:0]              parent_pos;

	assign left_pos   = {pos_q, 1'b0};
	assign right_pos  = left_pos + LW'(1);
	assign count_ext  = LW'(count_q);
	assign has_left   = (left_pos <= count_ext);
	assign take_right = (right_pos <= count_ext) && (rd_a_q < rd_b_q);
	assign child_val  = take_right ? rd_b_q : rd_a_q;
	assign child_pos  = take_right ? POS_W'(right_pos) : POS_W'(left_pos);
	assign parent_pos = pos_q >> 1;

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	// addresses, memory write and next position per state
	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		rd_addr_a = ADDR_W'(count_q - POS_W'(1));
		rd_addr_b = ADDR_W'(left_pos);
		wr_en     = 1'b0;
		wr_addr   = ADDR_W'(pos_q - POS_W'(1));
		wr_data   = value_q;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					case (q_head.op)
						mhpq_pkg::OP_PUSH: begin
							pos_d   = count_q + POS_W'(1);
							state_d = S_UP;
						end
						mhpq_pkg::OP_POP: begin
							if (count_q == POS_W'(1)) begin
								state_d = S_REPORT;
							end else begin
								state_d = S_LAST;
							end
						end
						default: begin
							state_d = S_REPORT;
						end
					endcase
				end
			end
			S_UP: begin
				if (pos_q == POS_W'(1)) begin
					wr_en   = 1'b1;
					state_d = S_REPORT;
				end else begin
					rd_addr_a = ADDR_W'(parent_pos - POS_W'(1));
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (rd_a_q < value_q) begin
					wr_data = rd_a_q;
					pos_d   = parent_pos;
					state_d = S_UP;
				end else begin
					state_d = S_REPORT;
				end
			end
			S_LAST: begin
				pos_d   = POS_W'(1);
				state_d = S_DOWN;
			end
			S_DOWN: begin
				if (has_left) begin
					rd_addr_a = ADDR_W'(left_pos - LW'(1));
					rd_addr_b = ADDR_W'(left_pos);
					state_d   = S_DOWN_CMP;
				end else begin
					wr_en   = 1'b1;
					state_d = S_REPORT;
				end
			end
			S_DOWN_CMP: begin
				wr_en = 1'b1;
				if (value_q < child_val) begin
					wr_data = child_val;
					pos_d   = child_pos;
					state_d = S_DOWN;
				end else begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == '0)) begin
			top_q <= wr_data;
		end
		rd_a_q <= $signed(heap_mem[rd_addr_a]);
		rd_b_q <= $signed(heap_mem[rd_addr_b]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			value_q   <= '0;
			removed_q <= '0;
			status_q  <= mhpq_pkg::STATUS_OK;
			done_q    <= 1'b0;
			top_out_q <= '0;
			total_q   <= '0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			done_q  <= (state_q == S_REPORT);
			if (state_q == S_IDLE && !q_empty) begin
				value_q <= q_head.value;
				case (q_head.op)
					mhpq_pkg::OP_PUSH: begin
						removed_q <= '0;
						status_q  <= mhpq_pkg::STATUS_OK;
						count_q   <= count_q + POS_W'(1);
					end
					mhpq_pkg::OP_POP: begin
						removed_q <= top_q;
						status_q  <= mhpq_pkg::STATUS_OK;
						count_q   <= count_q - POS_W'(1);
					end
					mhpq_pkg::OP_REJECT_FULL: begin
						removed_q <= '0;
						status_q  <= mhpq_pkg::STATUS_FULL;
					end
					default: begin
						removed_q <= '0;
						status_q  <= mhpq_pkg::STATUS_EMPTY;
					end
				endcase
			end else if (state_q == S_LAST) begin
				value_q <= rd_a_q;
			end
			if (state_q == S_REPORT) begin
				top_out_q <= (count_q != '0) ? top_q : '0;
				total_q   <= mhpq_pkg::TOTAL_W'(count_q);
			end
		end
	end

	assign done          = done_q;
	assign removed_value = removed_q;
	assign top_value     = top_out_q;
	assign entry_total   = total_q;
	assign status        = status_q;

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
// top level of the binary max-heap priority queue
//
// channel   ports                                              handshake
// request   req_type, push_value                               start & !busy
// result    removed_value, top_value, entry_total, status      done, one cycle
//
// a request enters a two-entry queue at the edge where start is high and busy
// low; the engine takes it from the queue head once it is idle, so busy only
// rises while two requests wait behind the heap engine
// in the engine a push sifts up and a pop moves the last entry to the root
// and sifts it down; each tree level costs a memory read step and a
// compare/write step on the single write port of the heap memory
// rejected requests go straight to the report step; results leave through a
// register and the receiver cannot stall them
// reset clears the count and the queue; heap memory is never cleared
module max_heap_priority_queue #(
	parameter int CAPACITY = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic signed [31:0]              push_value,
	output logic                            done,
	output logic signed [31:0]              removed_value,
	output logic signed [31:0]              top_value,
	output logic [7:0]                      entry_total,
	output logic [1:0]                      status
);

	// classified request travelling from intake to engine
	mhpq_pkg::request_t q_req;
	mhpq_pkg::request_t q_head;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;

	// intake keeps its own count so full and empty are known on arrival
	mhpq_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.push_value (push_value),
		.q_full     (q_full),
		.busy       (busy),
		.q_push     (q_push),
		.q_req      (q_req)
	);

	// decouples intake from the engine
	mhpq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (q_req),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// heap memory and sift sequencer, one request at a time
	mhpq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_head        (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.done          (done),
		.removed_value (removed_value),
		.top_value     (top_value),
		.entry_total   (entry_total),
		.status        (status)
	);

endmodule
